[rtl/adam_pkg.sv]
// Shared widths, register codes, reset values and divider request types for the Adam engine.
package adam_pkg;

  localparam int unsigned ParamCountDefault = 4096;

  localparam int unsigned IdxW     = 12;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned LrW      = 24;
  localparam int unsigned PowW     = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CFG_BETA1 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BETA2 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LR    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_EPS   = 3'd3;

  localparam logic [CoefW-1:0] Beta1Reset = 16'd58982;
  localparam logic [CoefW-1:0] Beta2Reset = 16'd65470;
  localparam logic [LrW-1:0]   LrReset    = 24'd16777;
  localparam logic [CoefW-1:0] EpsReset   = 16'd1;
  localparam logic [PowW-1:0]  PowOne     = 17'h10000;

  // Shared restoring divider
  localparam int unsigned DivDW   = 72;
  localparam int unsigned DivVW   = 33;
  localparam int unsigned DivCntW = 7;

  // Root unit
  localparam int unsigned SqrtInW  = 64;
  localparam int unsigned SqrtOutW = 32;
  localparam int unsigned SqrtCntW = 5;

  typedef struct packed {
    logic             start;
    logic [DivDW-1:0] dividend;
    logic [DivVW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivDW-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/adam_parameter_update.sv]
// Adam update engine: one item at a time, one result per item.
// Per item: moment read-modify-write, then the two bias-correction divisions (each
// skipped when its denominator is zero), the root and the step division, all three
// divisions on the shared 72-bit divider. An index at or past PARAM_COUNT is folded by
// repeated subtraction of PARAM_COUNT before the read. A finished beat waits in the
// output register while the next item is accepted. Reset: registers to defaults, powers
// to one, then a memory sweep over every entry with no input taken.
module adam_parameter_update #(
  parameter int unsigned PARAM_COUNT = adam_pkg::ParamCountDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [adam_pkg::IdxW-1:0]     param_index_i,
  input  logic signed [adam_pkg::DataW-1:0] gradient_i,
  input  logic signed [adam_pkg::DataW-1:0] param_value_i,
  input  logic                          first_of_epoch_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [adam_pkg::IdxW-1:0]     out_index_o,
  output logic signed [adam_pkg::DataW-1:0] new_value_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [adam_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [adam_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MOD  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_MA   = 4'd3;
  localparam logic [3:0] S_MB   = 4'd4;
  localparam logic [3:0] S_WB   = 4'd5;
  localparam logic [3:0] S_DM   = 4'd6;
  localparam logic [3:0] S_SH   = 4'd7;
  localparam logic [3:0] S_DS   = 4'd8;
  localparam logic [3:0] S_SQS  = 4'd9;
  localparam logic [3:0] S_SQ   = 4'd10;
  localparam logic [3:0] S_LR   = 4'd11;
  localparam logic [3:0] S_LP   = 4'd12;
  localparam logic [3:0] S_DV   = 4'd13;
  localparam logic [3:0] S_RES  = 4'd14;

  localparam logic [39:0] ShatCap = {40{1'b1}};
  localparam logic [40:0] StepCap = 41'h100_0000_0000;

  logic [3:0] state_q, state_d;

  // Configuration registers and running powers
  logic [adam_pkg::CoefW-1:0] beta1_q, beta2_q, eps_q;
  logic [adam_pkg::LrW-1:0]   lr_q;
  logic [adam_pkg::PowW-1:0]  b1p_q, b2p_q;
  logic [32:0]                pw1, pw2;

  // Item registers
  logic [adam_pkg::IdxW-1:0]          idx_q, slot_q;
  logic signed [adam_pkg::DataW-1:0]  g_q, val_q;

  // Moment datapath
  logic [adam_pkg::DataW-1:0] rd_first, rd_second;
  logic                       store_ready;
  logic signed [16:0]         b1s;
  logic [16:0]                omb1, omb2;
  logic signed [17:0]         omb1s;
  logic signed [48:0]         pm1_d, pm1_q;
  logic signed [49:0]         pm2_d, pm2_q;
  logic signed [50:0]         msum;
  logic [31:0]                gmag;
  logic [63:0]                gg_d, gg_q;
  logic signed [31:0]         m_q;
  logic [31:0]                gsq_q;
  logic [47:0]                ps1_q;
  logic [48:0]                ps2_q;
  logic [49:0]                ssum;
  logic [31:0]                s_new, s_q;
  logic [31:0]                mabs;
  logic [16:0]                d1, d2;

  // Correction, root and step
  logic [47:0] amag_q;
  logic        neg_q;
  logic [39:0] shat_q;
  logic [32:0] den_d, den_q;
  logic [47:0] pl_q, ph_q;
  logic [40:0] step_q;
  logic signed [42:0] res;
  logic [31:0] res_sat;

  adam_pkg::div_req_t div_req;
  adam_pkg::div_rsp_t div_rsp;
  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;

  logic out_valid_q;
  logic load_out;

  // Moment memories
  adam_store #(
    .PARAM_COUNT (PARAM_COUNT),
    .AW          (AW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (state_q == S_MOD && {5'b0, slot_q} < 17'(PARAM_COUNT)),
    .rd_addr_i   (AW'(slot_q)),
    .wr_en_i     (state_q == S_WB),
    .wr_addr_i   (AW'(slot_q)),
    .wr_first_i  (m_q),
    .wr_second_i (s_new),
    .rd_first_o  (rd_first),
    .rd_second_o (rd_second),
    .ready_o     (store_ready)
  );

  adam_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  adam_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i ({shat_q, 24'b0}),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  assign in_stall_o  = !(state_q == S_IDLE && store_ready);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  // Arithmetic between registers
  always_comb begin
    pw1   = 33'(b1p_q) * 33'(beta1_q);
    pw2   = 33'(b2p_q) * 33'(beta2_q);
    b1s   = $signed({1'b0, beta1_q});
    omb1  = adam_pkg::PowOne - {1'b0, beta1_q};
    omb2  = adam_pkg::PowOne - {1'b0, beta2_q};
    omb1s = $signed({1'b0, omb1});
    pm1_d = b1s * $signed(rd_first);
    pm2_d = omb1s * g_q;
    gmag  = g_q[31] ? (~g_q + 1'b1) : g_q;
    gg_d  = gmag * gmag;
    msum  = pm1_q + pm2_q;
    ssum  = ps1_q + ps2_q;
    s_new = ssum[47:16];
    mabs  = m_q[31] ? (~m_q + 1'b1) : m_q;
    d1    = adam_pkg::PowOne - b1p_q;
    d2    = adam_pkg::PowOne - b2p_q;
    den_d = 33'(sqrt_root) + 33'(eps_q);
    res   = neg_q ? (43'(val_q) + $signed({2'b00, step_q}))
                  : (43'(val_q) - $signed({2'b00, step_q}));
    if (res > 43'sd2147483647) begin
      res_sat = 32'h7FFF_FFFF;
    end else if (res < -43'sd2147483648) begin
      res_sat = 32'h8000_0000;
    end else begin
      res_sat = res[31:0];
    end
  end

  // Divider and root launch
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    sqrt_start       = (state_q == S_SQS);
    case (state_q)
      S_WB: begin
        div_req.start    = (d1 != '0);
        div_req.dividend = 72'({mabs, 16'b0});
        div_req.divisor  = 33'(d1);
      end
      S_SH: begin
        div_req.start    = (d2 != '0);
        div_req.dividend = 72'({s_q, 16'b0});
        div_req.divisor  = 33'(d2);
      end
      S_LP: begin
        div_req.start    = 1'b1;
        div_req.dividend = {ph_q, 24'b0} + 72'(pl_q);
        div_req.divisor  = den_q;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    case (state_q)
      S_IDLE: if (in_valid_i && !in_stall_o) state_d = S_MOD;
      S_MOD:  if ({5'b0, slot_q} < 17'(PARAM_COUNT)) state_d = S_RD;
      S_RD:   state_d = S_MA;
      S_MA:   state_d = S_MB;
      S_MB:   state_d = S_WB;
      S_WB:   state_d = (d1 != '0) ? S_DM : S_SH;
      S_DM:   if (div_rsp.done) state_d = S_SH;
      S_SH:   state_d = (d2 != '0) ? S_DS : S_SQS;
      S_DS:   if (div_rsp.done) state_d = S_SQS;
      S_SQS:  state_d = S_SQ;
      S_SQ:   if (sqrt_done) state_d = S_LR;
      S_LR:   state_d = S_LP;
      S_LP:   state_d = S_DV;
      S_DV:   if (div_rsp.done) state_d = S_RES;
      S_RES: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, configuration and powers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      beta1_q     <= adam_pkg::Beta1Reset;
      beta2_q     <= adam_pkg::Beta2Reset;
      lr_q        <= adam_pkg::LrReset;
      eps_q       <= adam_pkg::EpsReset;
      b1p_q       <= adam_pkg::PowOne;
      b2p_q       <= adam_pkg::PowOne;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          adam_pkg::CFG_BETA1: beta1_q <= cfg_data_i[adam_pkg::CoefW-1:0];
          adam_pkg::CFG_BETA2: beta2_q <= cfg_data_i[adam_pkg::CoefW-1:0];
          adam_pkg::CFG_LR:    lr_q    <= cfg_data_i;
          adam_pkg::CFG_EPS:   eps_q   <= cfg_data_i[adam_pkg::CoefW-1:0];
          default: ;
        endcase
      end
      // On the first item of an epoch, advance the powers ahead of this item's correction
      if (state_q == S_IDLE && in_valid_i && !in_stall_o && first_of_epoch_i) begin
        b1p_q <= pw1[32:16];
        b2p_q <= pw2[32:16];
      end
    end
  end

  // Item datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        idx_q  <= param_index_i;
        slot_q <= param_index_i;
        g_q    <= gradient_i;
        val_q  <= param_value_i;
      end
      S_MOD: begin
        if ({5'b0, slot_q} >= 17'(PARAM_COUNT)) begin
          slot_q <= slot_q - adam_pkg::IdxW'(PARAM_COUNT);
        end
      end
      S_RD: begin
        pm1_q <= pm1_d;
        pm2_q <= pm2_d;
        gg_q  <= gg_d;
      end
      S_MA: begin
        m_q   <= msum[47:16];
        gsq_q <= (gg_q[63:56] != '0) ? 32'hFFFF_FFFF : gg_q[55:24];
      end
      S_MB: begin
        ps1_q <= beta2_q * rd_second;
        ps2_q <= omb2 * gsq_q;
      end
      S_WB: begin
        s_q    <= s_new;
        neg_q  <= m_q[31];
        amag_q <= 48'(mabs);
      end
      S_DM: begin
        if (div_rsp.done) amag_q <= div_rsp.quotient[47:0];
      end
      S_SH: begin
        shat_q <= 40'(s_q);
      end
      S_DS: begin
        if (div_rsp.done) begin
          shat_q <= (div_rsp.quotient[71:40] != '0) ? ShatCap : div_rsp.quotient[39:0];
        end
      end
      S_SQ: begin
        if (sqrt_done) den_q <= (den_d == '0) ? 33'd1 : den_d;
      end
      S_LR: begin
        pl_q <= lr_q * amag_q[23:0];
        ph_q <= lr_q * amag_q[47:24];
      end
      S_DV: begin
        if (div_rsp.done) begin
          step_q <= (div_rsp.quotient[71:40] != '0) ? StepCap : div_rsp.quotient[40:0];
        end
      end
      S_RES: begin
        if (load_out) begin
          out_index_o <= idx_q;
          new_value_o <= res_sat;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/adam_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all divisions of the engine.
module adam_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  adam_pkg::div_req_t  req_i,
  output adam_pkg::div_rsp_t  rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [adam_pkg::DivCntW-1:0]  cnt_q;
  logic [adam_pkg::DivDW-1:0]    quo_q;
  logic [adam_pkg::DivVW-1:0]    rem_q;
  logic [adam_pkg::DivVW-1:0]    dvs_q;
  logic [adam_pkg::DivVW:0]      trial;
  logic                          ge;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[adam_pkg::DivDW-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == adam_pkg::DivCntW'(adam_pkg::DivDW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[adam_pkg::DivDW-2:0], ge};
      rem_q <= ge ? adam_pkg::DivVW'(trial - {1'b0, dvs_q}) : trial[adam_pkg::DivVW-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[rtl/adam_sqrt.sv]
// Digit-by-digit integer square root, one result bit per cycle.
module adam_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [adam_pkg::SqrtInW-1:0]  radicand_i,
  output logic                          done_o,
  output logic [adam_pkg::SqrtOutW-1:0] root_o
);

  logic                           busy_q;
  logic                           done_q;
  logic [adam_pkg::SqrtCntW-1:0]  cnt_q;
  logic [adam_pkg::SqrtInW-1:0]   x_q;
  logic [adam_pkg::SqrtOutW-1:0]  root_q;
  logic [adam_pkg::SqrtOutW+1:0]  rem_q;
  logic [adam_pkg::SqrtOutW+3:0]  t;
  logic [adam_pkg::SqrtOutW+3:0]  trial;
  logic                           ge;

  // Bring down the next two bits and test against 4*root+1
  assign t     = {rem_q, x_q[adam_pkg::SqrtInW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = (t >= trial);

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == adam_pkg::SqrtCntW'(adam_pkg::SqrtOutW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[adam_pkg::SqrtInW-3:0], 2'b00};
      root_q <= {root_q[adam_pkg::SqrtOutW-2:0], ge};
      rem_q  <= ge ? (adam_pkg::SqrtOutW+2)'(t - trial) : t[adam_pkg::SqrtOutW+1:0];
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[rtl/adam_store.sv]
// Moment memories: first and second moment per index, cleared by a sweep after reset.
module adam_store #(
  parameter int unsigned PARAM_COUNT = adam_pkg::ParamCountDefault,
  parameter int unsigned AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [AW-1:0]              rd_addr_i,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [adam_pkg::DataW-1:0] wr_first_i,
  input  logic [adam_pkg::DataW-1:0] wr_second_i,
  output logic [adam_pkg::DataW-1:0] rd_first_o,
  output logic [adam_pkg::DataW-1:0] rd_second_o,
  output logic                       ready_o
);

  logic [adam_pkg::DataW-1:0] first_mem  [PARAM_COUNT];
  logic [adam_pkg::DataW-1:0] second_mem [PARAM_COUNT];

  logic [AW:0]                clr_q;
  logic                       clearing;
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [adam_pkg::DataW-1:0] wfirst;
  logic [adam_pkg::DataW-1:0] wsecond;

  assign clearing = (clr_q != (AW+1)'(PARAM_COUNT));
  assign ready_o  = !clearing;

  // Advance the clearing sweep, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Select the write port source
  always_comb begin
    we      = clearing || wr_en_i;
    waddr   = clearing ? clr_q[AW-1:0] : wr_addr_i;
    wfirst  = clearing ? '0 : wr_first_i;
    wsecond = clearing ? '0 : wr_second_i;
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      first_mem[waddr]  <= wfirst;
      second_mem[waddr] <= wsecond;
    end
    if (rd_en_i) begin
      rd_first_o  <= first_mem[rd_addr_i];
      rd_second_o <= second_mem[rd_addr_i];
    end
  end

endmodule

[rtl/adam_checker.sv]
// Port-level checks for the Adam engine and their binding to the top level.
module adam_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [adam_pkg::IdxW-1:0]     param_index_i,
  input logic signed [adam_pkg::DataW-1:0] gradient_i,
  input logic signed [adam_pkg::DataW-1:0] param_value_i,
  input logic                          first_of_epoch_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [adam_pkg::IdxW-1:0]     out_index_o,
  input logic signed [adam_pkg::DataW-1:0] new_value_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [adam_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [adam_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [adam_pkg::IdxW-1:0] last_idx_q;

  // Hold the index of the last accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_idx_q <= '0;
    end else if (in_valid_i && !in_stall_o) begin
      last_idx_q <= param_index_i;
    end
  end

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_index_o) && $stable(new_value_o))
    else $error("result beat changed while stalled");

  // One item in the engine at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second beat accepted while busy");

  // A fresh result carries the index of the last accepted beat
  a_idx_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> out_index_o == last_idx_q)
    else $error("result index does not match accepted beat");

  // Configuration writes are always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind adam_parameter_update adam_checker u_adam_checker (.*);
